// File: hw/rtl/chi_pkg.sv
// Shared types and codes for the chained hash insert-if-absent block.
package chi_pkg;

    localparam int INODE_W  = 64;
    localparam int DEVICE_W = 64;
    localparam int PTAG_W   = 32;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 2;
    localparam logic [CFG_W-1:0] BUCKETS_RESET = 11'd1024;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t             req_type;
        logic [INODE_W-1:0]    inode;
        logic [DEVICE_W-1:0]   device;
        logic [PTAG_W-1:0]     path_tag;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [PTAG_W-1:0]     found_tag;
    } rsp_t;

endpackage

// File: hw/rtl/chi_ram.sv
// Generic simple dual-port RAM with registered read.
module chi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/chi_mod.sv
// Bit-serial restoring remainder unit: 64-bit dividend, one bit per cycle.
module chi_mod #(
    parameter int DW = 11,
    parameter int RW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [chi_pkg::INODE_W-1:0] dividend,
    input  logic [DW-1:0]               divisor,
    output logic                        done,
    output logic [RW-1:0]               rem
);
    import chi_pkg::*;

    localparam int CNT_W = $clog2(INODE_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [INODE_W-1:0]  dvd_reg;
    logic [DW-1:0]       rem_reg;
    logic [DW:0]         trial;
    logic [DW-1:0]       rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[INODE_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = DW'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(INODE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[INODE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[RW-1:0];

endmodule

// File: hw/rtl/chained_hash_insert_if_absent.sv
// Top level: insert-if-absent hash table with chained buckets in a fixed pool.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------
//  in      | in  | in_valid / in_stall | in_data  (chi_pkg::req_t)
//  out     | out | out_valid/ out_stall| out_data (chi_pkg::rsp_t)
//  cfg     | in  | cfg_we              | cfg_wdata (bucket count)
//
// Insert: the serial remainder unit shifts the whole inode and raises its
// done flag, then the head is read (S_HREAD, S_HCHK), each chain entry
// visited is read from the registered entry RAM (S_EREAD, S_ECHK), then
// the result is written (S_INS) and handed off (S_DONE) to out_valid.
// Clear: every bucket head is written, one bucket head per cycle.
// After reset the same head sweep runs before the first transfer is taken;
// cfg writes are taken meanwhile.
// in_stall is high whenever a request is in work; a finished result waits
// in the output register while out_stall is high, and the next request
// may be taken as soon as the result is registered.
module chained_hash_insert_if_absent #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_ENTRIES = 1024,
    parameter int TAG_BITS    = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  chi_pkg::req_t            in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output chi_pkg::rsp_t            out_data,
    input  logic                     cfg_we,
    input  logic [chi_pkg::CFG_W-1:0] cfg_wdata
);
    import chi_pkg::*;

    localparam int BW   = $clog2(MAX_BUCKETS);        // bucket index
    localparam int DW   = $clog2(MAX_BUCKETS + 1);    // divisor
    localparam int IW   = $clog2(MAX_ENTRIES);        // pool index
    localparam int TW   = (TAG_BITS > PTAG_W) ? TAG_BITS : PTAG_W;
    localparam int HW   = IW + 1;                     // head: valid + index
    localparam int EW   = INODE_W + DEVICE_W + TAG_BITS + IW + 1;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_MOD, S_HREAD, S_HCHK, S_EREAD, S_ECHK, S_INS, S_DONE
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic [IW:0]          used_reg;
    logic [BW-1:0]        sweep_reg;
    logic                 clr_pend_reg;
    logic [BW-1:0]        bucket_reg;
    logic [HW-1:0]        head_reg;
    logic [IW-1:0]        cur_reg;
    req_t                 req_reg;
    rsp_t                 rsp_reg;
    logic                 out_valid_reg;
    rsp_t                 out_reg;

    logic                 in_fire;
    logic                 out_free;
    logic [DW-1:0]        divisor;
    logic                 mod_start;
    logic                 mod_done;
    logic [BW-1:0]        mod_rem;

    logic                 h_we;
    logic [BW-1:0]        h_waddr;
    logic [HW-1:0]        h_wdata;
    logic [HW-1:0]        h_rdata;
    logic                 e_we;
    logic [EW-1:0]        e_wdata;
    logic [EW-1:0]        e_rdata;

    logic [INODE_W-1:0]   e_inode;
    logic [DEVICE_W-1:0]  e_device;
    logic [TAG_BITS-1:0]  e_tag;
    logic [IW-1:0]        e_next;
    logic                 e_next_valid;
    logic [TW-1:0]        tag_in_wide;
    logic [TW-1:0]        tag_out_wide;
    logic                 pool_full;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pool_full = (used_reg >= (IW+1)'(MAX_ENTRIES));

    // zero count acts as one bucket, counts above the table size saturate
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            divisor = DW'(1);
        end
        else if (32'(cfg_reg) > MAX_BUCKETS)
        begin
            divisor = DW'(MAX_BUCKETS);
        end
        else
        begin
            divisor = DW'(cfg_reg);
        end
    end

    assign mod_start = in_fire && (in_data.req_type == REQ_INSERT);

    chi_mod #(.DW(DW), .RW(BW)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (in_data.inode),
        .divisor  (divisor),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // head RAM: sweep writes empty heads, insert links the new entry
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = bucket_reg;
        h_wdata = {1'b1, used_reg[IW-1:0]};
        if (state_reg == S_SWEEP)
        begin
            h_we    = 1'b1;
            h_waddr = sweep_reg;
            h_wdata = '0;
        end
        else if (state_reg == S_INS && !pool_full)
        begin
            h_we = 1'b1;
        end
    end

    chi_ram #(.WIDTH(HW), .DEPTH(MAX_BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (bucket_reg),
        .rdata (h_rdata)
    );

    assign tag_in_wide = TW'(req_reg.path_tag);
    assign e_we        = (state_reg == S_INS) && !pool_full;
    assign e_wdata     = {req_reg.inode, req_reg.device, tag_in_wide[TAG_BITS-1:0],
                          head_reg[IW-1:0], head_reg[IW]};

    chi_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (used_reg[IW-1:0]),
        .wdata (e_wdata),
        .raddr (cur_reg),
        .rdata (e_rdata)
    );

    assign {e_inode, e_device, e_tag, e_next, e_next_valid} = e_rdata;
    assign tag_out_wide = TW'(e_tag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            cfg_reg       <= BUCKETS_RESET;
            used_reg      <= '0;
            sweep_reg     <= '0;
            clr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            // a new result in S_DONE takes priority over the drain
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_reg == BW'(MAX_BUCKETS - 1))
                    begin
                        sweep_reg <= '0;
                        if (clr_pend_reg)
                        begin
                            clr_pend_reg <= 1'b0;
                            rsp_reg      <= '{status: ST_CLEARED, found_tag: '0};
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_reg <= in_data;
                        if (in_data.req_type == REQ_CLEAR)
                        begin
                            used_reg     <= '0;
                            clr_pend_reg <= 1'b1;
                            state_reg    <= S_SWEEP;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        bucket_reg <= mod_rem;
                        state_reg  <= S_HREAD;
                    end
                end
                S_HREAD:
                begin
                    state_reg <= S_HCHK;
                end
                S_HCHK:
                begin
                    head_reg <= h_rdata;
                    cur_reg  <= h_rdata[IW-1:0];
                    state_reg <= h_rdata[IW] ? S_EREAD : S_INS;
                end
                S_EREAD:
                begin
                    state_reg <= S_ECHK;
                end
                S_ECHK:
                begin
                    if (e_inode == req_reg.inode && e_device == req_reg.device)
                    begin
                        rsp_reg   <= '{status: ST_PRESENT, found_tag: tag_out_wide[PTAG_W-1:0]};
                        state_reg <= S_DONE;
                    end
                    else if (e_next_valid)
                    begin
                        cur_reg   <= e_next;
                        state_reg <= S_EREAD;
                    end
                    else
                    begin
                        state_reg <= S_INS;
                    end
                end
                S_INS:
                begin
                    if (pool_full)
                    begin
                        rsp_reg <= '{status: ST_FULL, found_tag: '0};
                    end
                    else
                    begin
                        used_reg <= used_reg + 1'b1;
                        rsp_reg  <= '{status: ST_INSERTED, found_tag: '0};
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= rsp_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (IW+1)'(MAX_ENTRIES))
        else $error("pool fill count past capacity");

    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder finished outside hash phase");

    a_walk_linked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ECHK |-> {1'b0, cur_reg} < used_reg)
        else $error("chain walk reached an unlinked entry");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS && !pool_full) |=> used_reg == $past(used_reg) + 1'b1)
        else $error("insert did not advance the pool");
`endif

endmodule

// File: test/chained_hash_insert_if_absent_test.sv
// Self-checking testbench for the chained hash insert-if-absent table.
`timescale 1ns / 100ps

module chained_hash_insert_if_absent_test;
    import chi_pkg::*;

    localparam int BUCKETS_MAX  = 1024;
    localparam int POOL_SIZE    = 1024;
    localparam int WATCHDOG_MAX = 20000;
    localparam int HOLD_CYCLES  = 400;

    // Scoreboard: a shadow copy of the table predicts each response,
    // responses are matched in order against the queue of predictions.
    class hash_scoreboard;
        int          errors;
        rsp_t        expected_rsp[$];
        logic [10:0] bucket_cfg;
        int unsigned head[BUCKETS_MAX];
        bit          head_ok[BUCKETS_MAX];
        logic [63:0] key_inode[POOL_SIZE];
        logic [63:0] key_device[POOL_SIZE];
        logic [31:0] key_tag[POOL_SIZE];
        int unsigned link[POOL_SIZE];
        bit          link_ok[POOL_SIZE];
        int unsigned used;

        function new();
            errors = 0;
            bucket_cfg = BUCKETS_RESET;
            wipe();
        endfunction

        function void wipe();
            foreach (head_ok[i]) head_ok[i] = 1'b0;
            used = 0;
        endfunction

        function void set_buckets(logic [10:0] v);
            bucket_cfg = v;
        endfunction

        // Clear wipes all; else search the chain, insert at its head if absent and room.
        function rsp_t find_or_insert(req_t r);
            rsp_t        res;
            int unsigned divisor;
            int unsigned b;
            int unsigned cur;
            bit          have;
            res.status = ST_INSERTED;
            res.found_tag = '0;
            if (r.req_type == REQ_CLEAR)
            begin
                wipe();
                res.status = ST_CLEARED;
                return res;
            end
            divisor = (bucket_cfg == 0) ? 1 :
                      (bucket_cfg > BUCKETS_MAX) ? BUCKETS_MAX : bucket_cfg;
            b = int'(r.inode % 64'(divisor));
            have = head_ok[b];
            cur = head[b];
            while (have)
            begin
                if (key_inode[cur] == r.inode && key_device[cur] == r.device)
                begin
                    res.status = ST_PRESENT;
                    res.found_tag = key_tag[cur];
                    return res;
                end
                have = link_ok[cur];
                cur = link[cur];
            end
            if (used >= POOL_SIZE)
            begin
                res.status = ST_FULL;
                return res;
            end
            key_inode[used] = r.inode;
            key_device[used] = r.device;
            key_tag[used] = r.path_tag;
            link[used] = head[b];
            link_ok[used] = head_ok[b];
            head[b] = used;
            head_ok[b] = 1'b1;
            used++;
            return res;
        endfunction

        function void note_request(req_t r);
            expected_rsp.push_back(find_or_insert(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response: status %0d found_tag %h",
                       got.status, got.found_tag);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.found_tag !== want.found_tag)
            begin
                $error("found_tag: expected %h, got %h", want.found_tag, got.found_tag);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        in_data;
    logic        out_valid;
    logic        out_stall;
    rsp_t        out_data;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    hash_scoreboard table_model;
    int          send_idle_pct;  // sender idle chance per cycle
    int          recv_idle_pct;  // receiver stall chance per cycle
    bit          hold_request;   // asks the receiver for one long hold-off
    int          quiet_cycles;   // cycles since the last transfer
    logic [127:0] known_keys[$]; // {inode, device} pairs sent so far

    chained_hash_insert_if_absent dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Monitor: both channels are sampled at the edge, before the DUT's
    // registers move, so a transfer is seen exactly where it happens.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            table_model.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
            table_model.check_response(out_data);
    end

    // Watchdog: only cycles without any transfer or cfg write count toward the limit.
    // The limit covers the reset sweep, a clear sweep, the long hold-off
    // and a walk down a chain as long as the whole pool.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // result register fills and the input side backs up.
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until the transfer happens.
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_insert(logic [63:0] ino, logic [63:0] dev, logic [31:0] tag);
        req_t r;
        r.req_type = REQ_INSERT;
        r.inode = ino;
        r.device = dev;
        r.path_tag = tag;
        known_keys.push_back({ino, dev});
        send_request(r);
    endtask

    // Clear carries random junk in the ignored fields.
    task automatic send_clear();
        req_t r;
        r.req_type = REQ_CLEAR;
        r.inode = {$urandom, $urandom};
        r.device = {$urandom, $urandom};
        r.path_tag = $urandom;
        send_request(r);
    endtask

    // Register writes only once the table is idle and all results are back.
    task automatic write_buckets(logic [10:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (table_model.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_model.set_buckets(v);
    endtask

    // Reused keys (hits), fresh keys, some with small inodes so chains
    // actually form, and a rare clear.
    task automatic random_mix(int count);
        logic [127:0] k;
        logic [63:0]  ino;
        int           pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_clear();
            else if (pick < 45 && known_keys.size() != 0)
            begin
                k = known_keys[$urandom_range(known_keys.size() - 1)];
                send_insert(k[127:64], k[63:0], $urandom);
            end
            else
            begin
                ino = (pick < 70) ? 64'($urandom_range(4095)) : {$urandom, $urandom};
                send_insert(ino, {$urandom, $urandom}, $urandom);
            end
        end
    endtask

    initial
    begin
        table_model = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 34;
        recv_idle_pct = 34;
        hold_request = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, repeat hits, clear, bucket count corners.
        send_insert('0, '0, '0);
        send_insert('1, '1, '1);
        send_insert('0, '1, 32'h5555_aaaa);
        send_insert('1, '0, 32'haaaa_5555);
        send_insert('0, '0, 32'h1234_5678);
        send_insert('1, '1, '0);
        send_insert(64'd1024, 64'd7, 32'h0000_0001);
        send_insert(64'd2048, 64'd7, 32'h8000_0000);
        send_insert(64'd1024, 64'd7, '1);
        send_clear();
        send_insert('0, '0, 32'hdead_beef);
        send_insert('0, '0, '0);
        write_buckets(11'd0);       // zero count acts as a single bucket
        send_insert(64'd5, 64'd1, 32'h1111_1111);
        send_insert(64'd9, 64'd1, 32'h2222_2222);
        send_insert(64'd5, 64'd1, '0);
        write_buckets(11'h7ff);     // above the bucket limit: saturates
        send_insert(64'd1029, 64'd3, 32'h3333_3333);
        send_insert(64'd5, 64'd1, '0);
        write_buckets(11'd1);       // changed with live entries, no rehash
        send_insert(64'd9, 64'd1, '0);
        send_insert(64'd1029, 64'd3, '0);
        send_clear();

        // Fill the pool: long hold-off first, then a stretch with no idling.
        write_buckets(BUCKETS_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i == 300)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 34;
            end
            send_insert({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        end
        // Full pool: absent keys are refused, present keys still hit.
        repeat (6)
        begin
            logic [127:0] k;
            k = known_keys[known_keys.size() - 1 - $urandom_range(POOL_SIZE - 1)];
            send_insert(k[127:64], k[63:0], $urandom);
            send_insert({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        end
        send_clear();
        known_keys.delete();

        // Random phases over several bucket counts, including the extremes.
        write_buckets(11'd1);
        random_mix(130);
        write_buckets(11'd3);
        send_clear();
        random_mix(90);
        write_buckets(11'd1024);
        random_mix(90);
        write_buckets(11'($urandom_range(2, 64)));
        send_clear();
        random_mix(90);
        write_buckets(11'($urandom_range(65, 2047)));
        random_mix(90);

        in_valid <= 1'b0;
        @(posedge clk);
        while (table_model.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (table_model.errors == 0 && table_model.expected_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
